/* rtl/mtd_pkg.sv */
// Shared types, character constants and token decode function for the Morse token decoder.
package mtd_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [6:0] CH_QMARK = 7'h3F;
    localparam logic [6:0] CH_PERIOD = 7'h2E;
    localparam logic [6:0] CH_HYPHEN = 7'h2D;
    localparam logic [6:0] CH_BLANK = 7'h20;
    localparam logic [6:0] CH_LF    = 7'h0A;

    localparam int unsigned NUM_CODES  = 36;
    localparam int unsigned NUM_LETTERS = 26;
    localparam logic [5:0]  HYPHEN_BITS = 6'h21;

    // dot/dash count per code, letters A..Z then digits 0..9
    localparam logic [2:0] CODE_LEN [NUM_CODES] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };

    // bit i set when symbol i is a dash
    localparam logic [5:0] CODE_BITS [NUM_CODES] = '{
        6'd2,  6'd1,  6'd5,  6'd1,  6'd0,  6'd4,  6'd3,  6'd0,  6'd0,  6'd14,
        6'd5,  6'd2,  6'd3,  6'd1,  6'd7,  6'd6,  6'd11, 6'd2,  6'd0,  6'd1,
        6'd4,  6'd8,  6'd6,  6'd9,  6'd13, 6'd3,
        6'd31, 6'd30, 6'd28, 6'd24, 6'd16, 6'd0,  6'd1,  6'd3,  6'd7,  6'd15
    };

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } mtd_res_t;

    typedef struct packed {
        logic [1:0] cnt;
        mtd_res_t   ent0;
        mtd_res_t   ent1;
    } mtd_push_t;

    function automatic logic [6:0] decode_token(
        input logic [4:0] len,
        input logic [5:0] bits,
        input logic       dd,
        input logic [7:0] b0,
        input logic [7:0] b1
    );
        logic [6:0] res;
        logic       found;
        res   = CH_QMARK;
        found = 1'b0;
        if (dd && len >= 5'd1 && len <= 5'd5) begin
            for (int k = 0; k < NUM_CODES; k++) begin
                if (!found && {2'b00, CODE_LEN[k]} == len && CODE_BITS[k] == bits) begin
                    found = 1'b1;
                    if (k < NUM_LETTERS)
                        res = 7'(65 + k);
                    else
                        res = 7'(48 + k - NUM_LETTERS);
                end
            end
        end else if (dd && len == 5'd6 && bits == HYPHEN_BITS) begin
            res = CH_HYPHEN;
        end else if (len == 5'd2 && b0 == CH_SLASH && b1 == CH_SLASH) begin
            res = CH_PERIOD;
        end else if (len == 5'd1) begin
            if (b0 == CH_SLASH)
                res = CH_BLANK;
            else if (b0 inside {8'h2C, 8'h3F, 8'h21, 8'h22, 8'h28, 8'h29, 8'h27,
                                8'h3A, 8'h3B, 8'h23})
                res = b0[6:0];
        end
        return res;
    endfunction

endpackage

/* rtl/mtd_out_queue.sv */
// Two-entry queue taking up to two results per cycle, one beat out per ready cycle.
module mtd_out_queue
    import mtd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mtd_push_t  push,
    output logic [1:0] space,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] char_out, [7] zero
    output logic       m_axis_tlast    // last_of_run
);

    mtd_res_t   mem [2];
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop   = (count_reg != 2'd0) && m_axis_tready;
    assign space = 2'(2'd2 - count_reg + {1'b0, pop});

    assign rd_ptr_next = rd_ptr_reg ^ pop;
    assign wr_ptr_next = wr_ptr_reg ^ push.cnt[0];
    assign count_next  = 2'(count_reg + push.cnt - {1'b0, pop});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem[wr_ptr_reg] <= push.ent0;
        if (push.cnt == 2'd2)
            mem[~wr_ptr_reg] <= push.ent1;
    end

    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tdata  = {1'b0, mem[rd_ptr_reg].ch};
    assign m_axis_tlast  = mem[rd_ptr_reg].last;

endmodule

/* rtl/morse_token_decoder_unit.sv */
// Top level: input register, token tracking and decode, result queue.
// A beat accepted is held in the input register and decoded there once the result
// queue has room; its results then go into the queue, which feeds the master side.
// Throughput: one input beat per cycle while the result queue has room; a newline
// closing a token gives two results, sent one per cycle while m_axis_tready is high.
// Reset (rst_n low, asynchronous): queue empty, no input held, token state cleared.
module morse_token_decoder_unit
    import mtd_pkg::*;
#(
    parameter int MAX_TOKEN_BYTES = 31
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
    input  logic       s_axis_tlast,   // end_of_input
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] char_out, [7] zero
    output logic       m_axis_tlast    // last_of_run
);

    localparam logic [4:0] MAX_LEN = 5'(MAX_TOKEN_BYTES);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;

    logic [4:0] len_reg,  len_next;
    logic [5:0] bits_reg, bits_next;
    logic       dd_reg,   dd_next;
    logic [7:0] b0_reg,   b0_next;
    logic [7:0] b1_reg,   b1_next;

    logic [4:0] add_len;
    logic [5:0] add_bits;
    logic       add_dd;
    logic [7:0] add_b0;
    logic [7:0] add_b1;
    logic       is_space;
    logic       is_nl;
    logic       is_add;
    logic       do_flush;
    logic [6:0] dec_char;
    logic [1:0] n_res;
    logic [1:0] space;
    logic       proc;
    logic       accept;
    mtd_push_t  push;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign proc          = in_valid_reg && (n_res <= space);
    assign s_axis_tready = !in_valid_reg || proc;
    assign in_valid_next = accept ? 1'b1 : (proc ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            len_reg      <= 5'd0;
            bits_reg     <= 6'd0;
            dd_reg       <= 1'b1;
            b0_reg       <= 8'd0;
            b1_reg       <= 8'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            len_reg      <= len_next;
            bits_reg     <= bits_next;
            dd_reg       <= dd_next;
            b0_reg       <= b0_next;
            b1_reg       <= b1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eoi_reg  <= s_axis_tlast;
        end
    end

    assign is_space = (in_byte_reg == CH_SPACE);
    assign is_nl    = (in_byte_reg == CH_NL);
    assign is_add   = !is_space && !is_nl;

    // token state after the held byte is taken in
    always_comb
    begin
        add_len  = len_reg;
        add_bits = bits_reg;
        add_dd   = dd_reg;
        add_b0   = b0_reg;
        add_b1   = b1_reg;
        if (is_add)
        begin
            add_len = 5'(len_reg + 5'd1);
            if (len_reg == 5'd0)
                add_b0 = in_byte_reg;
            else if (len_reg == 5'd1)
                add_b1 = in_byte_reg;
            if (in_byte_reg != CH_DOT && in_byte_reg != CH_DASH)
                add_dd = 1'b0;
            else if (in_byte_reg == CH_DASH && len_reg < 5'd6)
                add_bits = bits_reg | 6'(6'd1 << len_reg[2:0]);
        end
    end

    assign do_flush = (add_len != 5'd0) &&
                      (is_space || is_nl || in_eoi_reg || (is_add && add_len >= MAX_LEN));
    assign dec_char = decode_token(add_len, add_bits, add_dd, add_b0, add_b1);
    assign n_res    = 2'({1'b0, do_flush} + {1'b0, is_nl});

    always_comb
    begin
        len_next  = len_reg;
        bits_next = bits_reg;
        dd_next   = dd_reg;
        b0_next   = b0_reg;
        b1_next   = b1_reg;
        if (proc)
        begin
            if (do_flush)
            begin
                len_next  = 5'd0;
                bits_next = 6'd0;
                dd_next   = 1'b1;
                b0_next   = 8'd0;
                b1_next   = 8'd0;
            end
            else
            begin
                len_next  = add_len;
                bits_next = add_bits;
                dd_next   = add_dd;
                b0_next   = add_b0;
                b1_next   = add_b1;
            end
        end
    end

    always_comb
    begin
        push.cnt       = proc ? n_res : 2'd0;
        push.ent0.ch   = do_flush ? dec_char : CH_LF;
        push.ent0.last = (n_res == 2'd1);
        push.ent1.ch   = CH_LF;
        push.ent1.last = 1'b1;
    end

    mtd_out_queue u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .space         (space),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* test/tb_top.sv */
// Testbench for morse_token_decoder_unit: directed table plus random token streams, scoreboarded.
module tb_top;
    import mtd_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       eoi;
        logic       fixed;
        logic [1:0] n;
        logic [7:0] c0;
        logic [7:0] c1;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    // token tracker state
    logic [4:0] tok_len;
    logic [5:0] dash_map;
    logic       pure_code;
    logic [7:0] byte0;
    logic [7:0] byte1;

    char_beat_t chars_due[$];
    stim_row_t  dir_tab [26];
    stim_row_t  cur_row;
    int         fails;
    int         sent;
    int         quiet_cycles;
    bit         idle_on;

    int         got_n;
    logic [7:0] got_c0;
    logic [7:0] got_c1;
    char_beat_t seen;

    morse_token_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [7:0] code_char(input logic [2:0] len, input logic [5:0] bits);
        logic [7:0] c;
        c = "?";
        case ({len, bits})
            {3'd2, 6'd2}:  c = "A";
            {3'd4, 6'd1}:  c = "B";
            {3'd4, 6'd5}:  c = "C";
            {3'd3, 6'd1}:  c = "D";
            {3'd1, 6'd0}:  c = "E";
            {3'd4, 6'd4}:  c = "F";
            {3'd3, 6'd3}:  c = "G";
            {3'd4, 6'd0}:  c = "H";
            {3'd2, 6'd0}:  c = "I";
            {3'd4, 6'd14}: c = "J";
            {3'd3, 6'd5}:  c = "K";
            {3'd4, 6'd2}:  c = "L";
            {3'd2, 6'd3}:  c = "M";
            {3'd2, 6'd1}:  c = "N";
            {3'd3, 6'd7}:  c = "O";
            {3'd4, 6'd6}:  c = "P";
            {3'd4, 6'd11}: c = "Q";
            {3'd3, 6'd2}:  c = "R";
            {3'd3, 6'd0}:  c = "S";
            {3'd1, 6'd1}:  c = "T";
            {3'd3, 6'd4}:  c = "U";
            {3'd4, 6'd8}:  c = "V";
            {3'd3, 6'd6}:  c = "W";
            {3'd4, 6'd9}:  c = "X";
            {3'd4, 6'd13}: c = "Y";
            {3'd4, 6'd3}:  c = "Z";
            {3'd5, 6'd31}: c = "0";
            {3'd5, 6'd30}: c = "1";
            {3'd5, 6'd28}: c = "2";
            {3'd5, 6'd24}: c = "3";
            {3'd5, 6'd16}: c = "4";
            {3'd5, 6'd0}:  c = "5";
            {3'd5, 6'd1}:  c = "6";
            {3'd5, 6'd3}:  c = "7";
            {3'd5, 6'd7}:  c = "8";
            {3'd5, 6'd15}: c = "9";
            default:       c = "?";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] token_char();
        logic [7:0] c;
        c = "?";
        if (pure_code && tok_len >= 5'd1 && tok_len <= 5'd5)
            c = code_char(tok_len[2:0], dash_map);
        else if (pure_code && tok_len == 5'd6 && dash_map == 6'b100001)
            c = "-";
        else if (tok_len == 5'd2 && byte0 == CH_SLASH && byte1 == CH_SLASH)
            c = ".";
        else if (tok_len == 5'd1)
        begin
            if (byte0 == CH_SLASH)
                c = " ";
            else
                case (byte0)
                    8'h2C, 8'h3F, 8'h21, 8'h22, 8'h28, 8'h29, 8'h27, 8'h3A, 8'h3B, 8'h23:
                        c = byte0;
                    default:
                        c = "?";
                endcase
        end
        return c;
    endfunction

    task automatic add_char(inout int n, inout logic [7:0] r0, inout logic [7:0] r1,
                            input logic [7:0] c);
        if (n == 0)
            r0 = c;
        else
            r1 = c;
        n++;
    endtask

    task automatic close_token(inout int n, inout logic [7:0] r0, inout logic [7:0] r1);
        if (tok_len != 5'd0)
        begin
            add_char(n, r0, r1, token_char());
            tok_len   = 5'd0;
            dash_map  = 6'd0;
            pure_code = 1'b1;
            byte0     = 8'd0;
            byte1     = 8'd0;
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic eoi, output int n,
                               output logic [7:0] r0, output logic [7:0] r1);
        n  = 0;
        r0 = 8'd0;
        r1 = 8'd0;
        if (b == CH_SPACE)
            close_token(n, r0, r1);
        else if (b == CH_NL)
        begin
            close_token(n, r0, r1);
            add_char(n, r0, r1, CH_NL);
        end
        else
        begin
            if (tok_len == 5'd0)
                byte0 = b;
            else if (tok_len == 5'd1)
                byte1 = b;
            if (b != CH_DOT && b != CH_DASH)
                pure_code = 1'b0;
            else if (b == CH_DASH && tok_len < 5'd6)
                dash_map = dash_map | (6'd1 << tok_len);
            tok_len = tok_len + 5'd1;
            if (tok_len == 5'd31)
                close_token(n, r0, r1);
        end
        if (eoi)
            close_token(n, r0, r1);
    endtask

    // scoreboard: predict on input beats, check output beats
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            absorb_byte(s_axis_tdata, s_axis_tlast, got_n, got_c0, got_c1);
            if (cur_row.fixed)
            begin
                got_n  = int'(cur_row.n);
                got_c0 = cur_row.c0;
                got_c1 = cur_row.c1;
            end
            if (got_n > 0)
                chars_due.push_back('{got_c0, got_n == 1});
            if (got_n > 1)
                chars_due.push_back('{got_c1, 1'b1});
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (chars_due.size() == 0)
            begin
                $error("unexpected beat: char_out %h last_of_run %b",
                       m_axis_tdata[6:0], m_axis_tlast);
                fails++;
            end
            else
            begin
                seen = chars_due.pop_front();
                if (m_axis_tdata[6:0] !== seen.ch[6:0])
                begin
                    $error("char_out expected %h actual %h", seen.ch[6:0], m_axis_tdata[6:0]);
                    fails++;
                end
                if (m_axis_tlast !== seen.last)
                begin
                    $error("last_of_run expected %b actual %b", seen.last, m_axis_tlast);
                    fails++;
                end
                if (m_axis_tdata[7] !== 1'b0)
                begin
                    $error("tdata pad expected 0 actual %b", m_axis_tdata[7]);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
        m_axis_tready <= idle_on ? ($urandom_range(99) >= 26) : 1'b1;

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000)
        begin
            $display("[morse_token_decoder_unit] ERROR");
            $finish;
        end
    end

    task automatic send_row(input stim_row_t r);
        while (idle_on && $urandom_range(99) < 26)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r.b;
        s_axis_tlast  <= r.eoi;
        cur_row       <= r;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
        idle_on = !(sent >= 600 && sent < 850);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_row('{b, ($urandom_range(99) < 3), 1'b0, 2'd0, 8'd0, 8'd0});
    endtask

    task automatic send_code(input int len);
        for (int i = 0; i < len; i++)
            send_byte($urandom_range(1) ? CH_DASH : CH_DOT);
    endtask

    initial
    begin
        int k;
        int len;
        logic [7:0] pick;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        cur_row       = '0;
        fails         = 0;
        sent          = 0;
        quiet_cycles  = 0;
        idle_on       = 1'b1;
        tok_len       = 5'd0;
        dash_map      = 6'd0;
        pure_code     = 1'b1;
        byte0         = 8'd0;
        byte1         = 8'd0;

        //            byte      eoi   fixed n     c0     c1
        dir_tab[0]  = '{CH_SPACE, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00};
        dir_tab[1]  = '{CH_NL,    1'b0, 1'b1, 2'd1, CH_NL, 8'h00};
        dir_tab[2]  = '{CH_DOT,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
        dir_tab[3]  = '{CH_DASH,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
        dir_tab[4]  = '{CH_SPACE, 1'b1, 1'b1, 2'd1, "A",   8'h00};
        dir_tab[5]  = '{CH_DASH,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
        dir_tab[6]  = '{CH_DASH,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
        dir_tab[7]  = '{CH_DASH,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
        dir_tab[8]  = '{CH_DASH,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
        dir_tab[9]  = '{CH_DASH,  1'b1, 1'b1, 2'd1, "0",   8'h00};
        dir_tab[10] = '{CH_SPACE, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00};
        dir_tab[11] = '{CH_DASH,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
        dir_tab[12] = '{CH_DOT,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
        dir_tab[13] = '{CH_DOT,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
        dir_tab[14] = '{CH_DOT,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
        dir_tab[15] = '{CH_DOT,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
        dir_tab[16] = '{CH_DASH,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
        dir_tab[17] = '{CH_NL,    1'b0, 1'b1, 2'd2, "-",   CH_NL};
        dir_tab[18] = '{CH_SLASH, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
        dir_tab[19] = '{CH_SLASH, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
        dir_tab[20] = '{CH_SPACE, 1'b0, 1'b1, 2'd1, ".",   8'h00};
        dir_tab[21] = '{CH_SLASH, 1'b1, 1'b1, 2'd1, " ",   8'h00};
        dir_tab[22] = '{"#",      1'b0, 1'b0, 2'd0, 8'h00, 8'h00};
        dir_tab[23] = '{CH_NL,    1'b0, 1'b1, 2'd2, "#",   CH_NL};
        dir_tab[24] = '{8'h00,    1'b1, 1'b1, 2'd1, "?",   8'h00};
        dir_tab[25] = '{8'hFF,    1'b1, 1'b1, 2'd1, "?",   8'h00};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 26; i++)
            send_row(dir_tab[i]);

        while (sent < 1326)
        begin
            k = $urandom_range(99);
            if (k < 55)
            begin
                len = $urandom_range(99);
                if (len < 85)
                    send_code($urandom_range(1, 5));
                else if (len < 93)
                begin
                    if ($urandom_range(1))
                    begin
                        send_byte(CH_DASH);
                        send_code(0);
                        for (int i = 0; i < 4; i++)
                            send_byte(CH_DOT);
                        send_byte(CH_DASH);
                    end
                    else
                        send_code(6);
                end
                else
                    send_code($urandom_range(7, 9));
            end
            else if (k < 63)
            begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    send_byte(CH_SLASH);
            end
            else if (k < 71)
            begin
                case ($urandom_range(11))
                    0: pick = ",";   1: pick = "?";   2: pick = "!";  3: pick = 8'h22;
                    4: pick = "(";   5: pick = ")";   6: pick = "'";  7: pick = ":";
                    8: pick = ";";   9: pick = "#";  10: pick = CH_SLASH;
                    default: pick = 8'($urandom_range(255));
                endcase
                send_byte(pick);
            end
            else if (k < 77)
            begin
                len = $urandom_range(6, 40);
                for (int i = 0; i < len; i++)
                begin
                    case ($urandom_range(3))
                        0: pick = CH_DOT;
                        1: pick = CH_DASH;
                        default: pick = 8'($urandom_range(255));
                    endcase
                    if (pick == CH_SPACE || pick == CH_NL)
                        pick = 8'h00;
                    send_byte(pick);
                end
            end
            else
            begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom_range(255)));
            end
            k = $urandom_range(9);
            if (k < 6)
                send_byte(CH_SPACE);
            else if (k < 8)
                send_byte(CH_NL);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (chars_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("[morse_token_decoder_unit] OK");
        else
            $display("[morse_token_decoder_unit] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/mtd_pkg.sv
rtl/mtd_out_queue.sv
rtl/morse_token_decoder_unit.sv
test/tb_top.sv
